// ----- design/cgpi_pkg.sv -----
// shared types, constants and the build-time weight table for the corner glow interpolator
package cgpi_pkg;

  localparam int PANEL_WIDTH      = 16;
  localparam int PANEL_HEIGHT     = 20;
  localparam int WEIGHT_FRAC_BITS = 16;

  localparam int CORNERS   = 4;
  localparam int CHANNELS  = 3;
  localparam int WEIGHT_W  = WEIGHT_FRAC_BITS + 1;
  localparam int COL_W     = 6;
  localparam int ROW_W     = 6;
  localparam int ROM_DEPTH = PANEL_WIDTH * PANEL_HEIGHT;
  localparam int ADDR_W    = $clog2(ROM_DEPTH);

  localparam logic OP_PIXEL     = 1'b0;
  localparam logic OP_FRAME_END = 1'b1;

  localparam logic [7:0] HUE_THIRD      = 8'd85;
  localparam logic [7:0] HUE_TWO_THIRDS = 8'd170;

  typedef logic [7:0]                  chan_t;
  typedef chan_t [CHANNELS-1:0]        rgb_t;
  typedef rgb_t [CORNERS-1:0]          corner_set_t;
  typedef logic [WEIGHT_W-1:0]         weight_t;
  typedef weight_t [CORNERS-1:0]       weight_set_t;
  typedef weight_set_t [ROM_DEPTH-1:0] weight_rom_t;

  function automatic longint unsigned isqrt64(input longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    longint unsigned m;
    r = 0;
    m = n;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (b > m) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 0) begin
        if (m >= r + b) begin
          m = m - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // shift-subtract quotient, evaluated at elaboration only
  function automatic longint unsigned udiv64(input longint unsigned n,
                                             input longint unsigned d);
    longint unsigned q;
    longint unsigned rem;
    q   = 0;
    rem = 0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], n[i]};
      if (rem >= d) begin
        rem  = rem - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic weight_rom_t build_weight_rom();
    weight_rom_t     rom;
    longint unsigned inv [CORNERS];
    longint unsigned sum;
    longint unsigned dx;
    longint unsigned dy;
    longint unsigned d2;
    int              cx;
    int              cy;
    bool_corner:
    begin
    end
    rom = '0;
    for (int y = 0; y < PANEL_HEIGHT; y++) begin
      for (int x = 0; x < PANEL_WIDTH; x++) begin
        if ((x == 0 || x == PANEL_WIDTH - 1) && (y == 0 || y == PANEL_HEIGHT - 1)) begin
          rom[y * PANEL_WIDTH + x] = '0;
        end else begin
          sum = 0;
          for (int k = 0; k < CORNERS; k++) begin
            cx = ((k & 1) != 0) ? PANEL_WIDTH - 1 : 0;
            cy = ((k & 2) != 0) ? PANEL_HEIGHT - 1 : 0;
            dx = (x > cx) ? longint'(x - cx) : longint'(cx - x);
            dy = (y > cy) ? longint'(y - cy) : longint'(cy - y);
            d2 = dx * dx + dy * dy;
            if (d2 == 0) d2 = 1;
            inv[k] = isqrt64(udiv64(64'd1 << 48, d2));
            sum    = sum + inv[k];
          end
          if (sum == 0) sum = 1;
          for (int k = 0; k < CORNERS; k++) begin
            rom[y * PANEL_WIDTH + x][k] =
              WEIGHT_W'(udiv64(inv[k] << WEIGHT_FRAC_BITS, sum));
          end
        end
      end
    end
    return rom;
  endfunction

  localparam weight_rom_t WEIGHT_ROM = build_weight_rom();

endpackage

// ----- design/cgpi_mix.sv -----
// weighted blend of the four corner colors for one interior pixel
module cgpi_mix (
  input  cgpi_pkg::weight_set_t weights,
  input  cgpi_pkg::corner_set_t corner_now,
  output cgpi_pkg::rgb_t        mix_rgb
);

  localparam int ACC_W = cgpi_pkg::WEIGHT_W + 8 + 2;

  logic [cgpi_pkg::CHANNELS-1:0][ACC_W-1:0] acc;

  always_comb begin
    for (int c = 0; c < cgpi_pkg::CHANNELS; c++) begin
      acc[c] = '0;
      for (int k = 0; k < cgpi_pkg::CORNERS; k++) begin
        acc[c] = acc[c] + ACC_W'(weights[k]) * ACC_W'(corner_now[k][c]);
      end
      mix_rgb[c] = acc[c][cgpi_pkg::WEIGHT_FRAC_BITS +: 8];
    end
  end

endmodule

// ----- design/corner_glow_pixel_interpolator_unit.sv -----
// top level of the corner glow pixel interpolator
// One beat is accepted per clock while in_stall is low. The first stage registers the beat
// with the corner weights read from the build-time weight ROM; the second steps or
// retargets the corner colors and loads the result register with a corner pixel's
// stepped color or, for any other pixel, a blend of the four corner colors. Corner
// state changes as a beat leaves the first stage, so each beat sees every earlier
// beat's update. A frame-end beat returns black with a bit per corner that took a new
// target; a pixel beat outside the panel returns all zero and changes nothing.
module corner_glow_pixel_interpolator_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       operation,
  input  logic [5:0] col,
  input  logic [5:0] row,
  input  logic [7:0] random_a,
  input  logic [7:0] random_b,
  input  logic [7:0] random_c,
  input  logic [7:0] random_d,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue,
  output logic [3:0] retargeted
);

  localparam int CN = cgpi_pkg::CORNERS;
  localparam int CH = cgpi_pkg::CHANNELS;

  logic                          in_accept;
  logic                          out_load;
  logic                          in_inside;
  logic [cgpi_pkg::ADDR_W-1:0]   rom_addr;

  logic                          s1_valid;
  logic                          op1;
  logic [5:0]                    col1;
  logic [5:0]                    row1;
  logic [CN-1:0][7:0]            rand1;
  cgpi_pkg::weight_set_t         weights1;

  cgpi_pkg::corner_set_t         corner_now;
  cgpi_pkg::corner_set_t         corner_now_next;
  cgpi_pkg::corner_set_t         corner_goal;
  cgpi_pkg::corner_set_t         corner_goal_next;
  cgpi_pkg::corner_set_t         stepped;
  logic [CN-1:0][CH-1:0][8:0]    gap;
  logic [CN-1:0]                 near;
  logic [CN-1:0]                 hit;
  logic                          inside1;
  cgpi_pkg::rgb_t                mix_rgb;
  cgpi_pkg::rgb_t                corner_rgb;
  cgpi_pkg::rgb_t                res_rgb;
  logic [3:0]                    res_mask;

  function automatic cgpi_pkg::rgb_t hue_wheel(input logic [7:0] v);
    logic [7:0]     t;
    cgpi_pkg::rgb_t h;
    t = v + {v[6:0], 1'b0};
    h[0] = ((v <= cgpi_pkg::HUE_THIRD) ? ~t : 8'd0)
         + ((v > cgpi_pkg::HUE_TWO_THIRDS) ? t : 8'd0);
    h[1] = ((v <= cgpi_pkg::HUE_THIRD) ? t : 8'd0)
         + ((v >= cgpi_pkg::HUE_THIRD && v < cgpi_pkg::HUE_TWO_THIRDS) ? ~t : 8'd0);
    h[2] = ((v > cgpi_pkg::HUE_THIRD && v <= cgpi_pkg::HUE_TWO_THIRDS) ? t : 8'd0)
         + ((v >= cgpi_pkg::HUE_TWO_THIRDS) ? ~t : 8'd0);
    return h;
  endfunction

  // handshake
  assign out_load  = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !out_load;
  assign in_accept = in_valid && !in_stall;

  // weight rom address, only meaningful inside the panel
  assign in_inside = (32'(col) < cgpi_pkg::PANEL_WIDTH) && (32'(row) < cgpi_pkg::PANEL_HEIGHT);
  assign rom_addr  = in_inside
                   ? cgpi_pkg::ADDR_W'(cgpi_pkg::ADDR_W'(row)
                       * cgpi_pkg::ADDR_W'(cgpi_pkg::PANEL_WIDTH) + cgpi_pkg::ADDR_W'(col))
                   : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op1      <= operation;
      col1     <= col;
      row1     <= row;
      rand1    <= {random_d, random_c, random_b, random_a};
      weights1 <= cgpi_pkg::WEIGHT_ROM[rom_addr];
    end
  end

  // corner geometry of the registered beat
  assign inside1 = (32'(col1) < cgpi_pkg::PANEL_WIDTH) && (32'(row1) < cgpi_pkg::PANEL_HEIGHT);

  always_comb begin
    hit[0] = (col1 == '0) && (row1 == '0);
    hit[1] = (32'(col1) == cgpi_pkg::PANEL_WIDTH - 1) && (row1 == '0);
    hit[2] = (col1 == '0) && (32'(row1) == cgpi_pkg::PANEL_HEIGHT - 1);
    hit[3] = (32'(col1) == cgpi_pkg::PANEL_WIDTH - 1)
          && (32'(row1) == cgpi_pkg::PANEL_HEIGHT - 1);
  end

  // step toward target and closeness test
  always_comb begin
    for (int k = 0; k < CN; k++) begin
      near[k] = 1'b1;
      for (int c = 0; c < CH; c++) begin
        gap[k][c] = {1'b0, corner_goal[k][c]} - {1'b0, corner_now[k][c]};
        if ($signed(gap[k][c]) > 9'sd1) begin
          stepped[k][c] = corner_now[k][c] + 8'd2;
        end else if ($signed(gap[k][c]) < -9'sd1) begin
          stepped[k][c] = corner_now[k][c] - 8'd2;
        end else begin
          stepped[k][c] = corner_now[k][c];
        end
        if ($signed(gap[k][c]) > 9'sd1 || $signed(gap[k][c]) < -9'sd1) begin
          near[k] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    corner_now_next  = corner_now;
    corner_goal_next = corner_goal;
    if (out_load) begin
      if (op1 == cgpi_pkg::OP_FRAME_END) begin
        for (int k = 0; k < CN; k++) begin
          if (near[k]) corner_goal_next[k] = hue_wheel(rand1[k]);
        end
      end else if (inside1) begin
        for (int k = 0; k < CN; k++) begin
          if (hit[k]) corner_now_next[k] = stepped[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_now  <= '0;
      corner_goal <= '0;
    end else begin
      corner_now  <= corner_now_next;
      corner_goal <= corner_goal_next;
    end
  end

  cgpi_mix u_mix (
    .weights   (weights1),
    .corner_now(corner_now),
    .mix_rgb   (mix_rgb)
  );

  always_comb begin
    corner_rgb = '0;
    for (int k = 0; k < CN; k++) begin
      if (hit[k]) corner_rgb = stepped[k];
    end
  end

  always_comb begin
    res_rgb  = '0;
    res_mask = '0;
    if (op1 == cgpi_pkg::OP_FRAME_END) begin
      res_mask = near;
    end else if (inside1) begin
      res_rgb = (hit != '0) ? corner_rgb : mix_rgb;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      red        <= res_rgb[0];
      green      <= res_rgb[1];
      blue       <= res_rgb[2];
      retargeted <= res_mask;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

  a_beat_not_lost: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_load |=> s1_valid)
    else $error("stage one beat dropped");

  a_state_quiet: assert property (@(posedge clk) disable iff (rst)
    !out_load |=> $stable(corner_now) && $stable(corner_goal))
    else $error("corner state changed without a beat");

  a_frame_end_black: assert property (@(posedge clk) disable iff (rst)
    out_load && op1 == cgpi_pkg::OP_FRAME_END |=> red == 8'd0 && green == 8'd0 && blue == 8'd0)
    else $error("frame-end result not black");

  a_pixel_no_retarget: assert property (@(posedge clk) disable iff (rst)
    out_load && op1 == cgpi_pkg::OP_PIXEL |=> retargeted == 4'd0 && $stable(corner_goal))
    else $error("pixel beat touched targets");

endmodule

// ----- test/tb_top.sv -----
// testbench for the corner glow pixel interpolator: table, raster-frame and random beats against a predictor
module tb_top;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [3:0] retargeted;
  } glow_t;

  typedef struct packed {
    logic       op;
    logic [5:0] col;
    logic [5:0] row;
    logic [7:0] ra;
    logic [7:0] rb;
    logic [7:0] rc;
    logic [7:0] rd;
    logic       known;
    logic [7:0] er;
    logic [7:0] eg;
    logic [7:0] eb;
    logic [3:0] em;
  } script_row_t;

  localparam int SCRIPT_LEN = 21;

  localparam logic OP_PIXEL     = cgpi_pkg::OP_PIXEL;
  localparam logic OP_FRAME_END = cgpi_pkg::OP_FRAME_END;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       operation = OP_PIXEL;
  logic [5:0] col = '0;
  logic [5:0] row = '0;
  logic [7:0] random_a = '0;
  logic [7:0] random_b = '0;
  logic [7:0] random_c = '0;
  logic [7:0] random_d = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [3:0] retargeted;

  longint unsigned glow_weight [cgpi_pkg::PANEL_HEIGHT][cgpi_pkg::PANEL_WIDTH][cgpi_pkg::CORNERS];
  logic [7:0]      glow_now [cgpi_pkg::CORNERS*cgpi_pkg::CHANNELS];
  logic [7:0]      glow_goal [cgpi_pkg::CORNERS*cgpi_pkg::CHANNELS];
  glow_t           pending_colors [$];
  int              color_mismatches = 0;
  bit              idle_on = 1'b1;
  int              stall_left = 0;

  script_row_t glow_script [SCRIPT_LEN] = '{
    '{OP_PIXEL,     6'd5,  6'd5,  8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 8'd0, 8'd0, 8'd0, 4'h0},
    '{OP_PIXEL,     6'd0,  6'd0,  8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 8'd0, 8'd0, 8'd0, 4'h0},
    '{OP_PIXEL,     6'd16, 6'd0,  8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 8'd0, 8'd0, 8'd0, 4'h0},
    '{OP_PIXEL,     6'd0,  6'd20, 8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 8'd0, 8'd0, 8'd0, 4'h0},
    '{OP_PIXEL,     6'd63, 6'd63, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 8'd0, 8'd0, 8'd0, 4'h0},
    '{OP_FRAME_END, 6'd63, 6'd63, 8'd0,   8'd85,  8'd170, 8'd255, 1'b1, 8'd0, 8'd0, 8'd0, 4'hF},
    '{OP_PIXEL,     6'd0,  6'd0,  8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 8'd2, 8'd0, 8'd0, 4'h0},
    '{OP_PIXEL,     6'd15, 6'd0,  8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 8'd0, 8'd2, 8'd0, 4'h0},
    '{OP_PIXEL,     6'd0,  6'd19, 8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 8'd0, 8'd0, 8'd2, 4'h0},
    '{OP_PIXEL,     6'd15, 6'd19, 8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 8'd2, 8'd0, 8'd2, 4'h0},
    '{OP_FRAME_END, 6'd0,  6'd0,  8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 8'd0, 8'd0, 8'd0, 4'h0},
    '{OP_PIXEL,     6'd1,  6'd0,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 8'd0, 8'd0, 4'h0},
    '{OP_PIXEL,     6'd14, 6'd19, 8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 8'd0, 8'd0, 4'h0},
    '{OP_PIXEL,     6'd0,  6'd10, 8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 8'd0, 8'd0, 4'h0},
    '{OP_PIXEL,     6'd15, 6'd10, 8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 8'd0, 8'd0, 4'h0},
    '{OP_PIXEL,     6'd7,  6'd9,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 8'd0, 8'd0, 4'h0},
    '{OP_PIXEL,     6'd15, 6'd1,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 8'd0, 8'd0, 4'h0},
    '{OP_PIXEL,     6'd1,  6'd18, 8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 8'd0, 8'd0, 4'h0},
    '{OP_PIXEL,     6'd16, 6'd19, 8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 8'd0, 8'd0, 8'd0, 4'h0},
    '{OP_PIXEL,     6'd15, 6'd20, 8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 8'd0, 8'd0, 8'd0, 4'h0},
    '{OP_FRAME_END, 6'd31, 6'd42, 8'd84,  8'd86,  8'd169, 8'd171, 1'b1, 8'd0, 8'd0, 8'd0, 4'h0}
  };

  corner_glow_pixel_interpolator_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .col        (col),
    .row        (row),
    .random_a   (random_a),
    .random_b   (random_b),
    .random_c   (random_c),
    .random_d   (random_d),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .retargeted (retargeted)
  );

  always #2 clk = ~clk;

  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    lo = 0;
    hi = 64'd1 << 25;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (mid * mid <= n) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic void build_weights();
    longint unsigned inv [cgpi_pkg::CORNERS];
    longint unsigned sum;
    longint unsigned dx;
    longint unsigned dy;
    longint unsigned d2;
    int              cx;
    int              cy;
    for (int y = 0; y < cgpi_pkg::PANEL_HEIGHT; y++) begin
      for (int x = 0; x < cgpi_pkg::PANEL_WIDTH; x++) begin
        sum = 0;
        for (int k = 0; k < cgpi_pkg::CORNERS; k++) begin
          cx = (k & 1) ? cgpi_pkg::PANEL_WIDTH - 1 : 0;
          cy = (k & 2) ? cgpi_pkg::PANEL_HEIGHT - 1 : 0;
          dx = (x > cx) ? x - cx : cx - x;
          dy = (y > cy) ? y - cy : cy - y;
          d2 = dx * dx + dy * dy;
          if (d2 == 0) d2 = 1;
          inv[k] = root_floor((64'd1 << 48) / d2);
          sum = sum + inv[k];
        end
        if (sum == 0) sum = 1;
        for (int k = 0; k < cgpi_pkg::CORNERS; k++) begin
          glow_weight[y][x][k] = (inv[k] << cgpi_pkg::WEIGHT_FRAC_BITS) / sum;
        end
      end
    end
  endfunction

  // index 0 red, 1 green, 2 blue; every term wraps at 8 bits
  function automatic logic [2:0][7:0] hue_wheel(input logic [7:0] v);
    logic [7:0]      t3;
    logic [7:0]      inv3;
    logic [2:0][7:0] rgb;
    t3 = v + v + v;
    inv3 = 8'd255 - t3;
    rgb[0] = (v <= cgpi_pkg::HUE_THIRD ? inv3 : 8'd0)
           + (v > cgpi_pkg::HUE_TWO_THIRDS ? t3 : 8'd0);
    rgb[1] = (v <= cgpi_pkg::HUE_THIRD ? t3 : 8'd0)
           + ((v >= cgpi_pkg::HUE_THIRD && v < cgpi_pkg::HUE_TWO_THIRDS) ? inv3 : 8'd0);
    rgb[2] = ((v > cgpi_pkg::HUE_THIRD && v <= cgpi_pkg::HUE_TWO_THIRDS) ? t3 : 8'd0)
           + (v >= cgpi_pkg::HUE_TWO_THIRDS ? inv3 : 8'd0);
    return rgb;
  endfunction

  function automatic glow_t next_pixel_color(input logic op, input logic [5:0] c,
                                             input logic [5:0] r,
                                             input logic [3:0][7:0] hues);
    glow_t           res;
    logic [2:0][7:0] px;
    logic [2:0][7:0] goal_rgb;
    longint unsigned acc;
    int              d;
    int              cn;
    int              i;
    bit              near;
    res = '0;
    px = '0;
    if (op == OP_FRAME_END) begin
      for (int k = 0; k < cgpi_pkg::CORNERS; k++) begin
        near = 1'b1;
        for (int ch = 0; ch < cgpi_pkg::CHANNELS; ch++) begin
          d = int'(glow_now[k*3+ch]) - int'(glow_goal[k*3+ch]);
          if (d > 1 || d < -1) near = 1'b0;
        end
        if (near) begin
          goal_rgb = hue_wheel(hues[k]);
          for (int ch = 0; ch < cgpi_pkg::CHANNELS; ch++) glow_goal[k*3+ch] = goal_rgb[ch];
          res.retargeted[k] = 1'b1;
        end
      end
      return res;
    end
    if (c >= cgpi_pkg::PANEL_WIDTH || r >= cgpi_pkg::PANEL_HEIGHT) return res;
    if ((c == 0 || c == cgpi_pkg::PANEL_WIDTH - 1) &&
        (r == 0 || r == cgpi_pkg::PANEL_HEIGHT - 1)) begin
      cn = (c != 0 ? 1 : 0) + (r != 0 ? 2 : 0);
      for (int ch = 0; ch < cgpi_pkg::CHANNELS; ch++) begin
        i = cn * 3 + ch;
        d = int'(glow_goal[i]) - int'(glow_now[i]);
        if (d > 1) glow_now[i] = glow_now[i] + 8'd2;
        else if (d < -1) glow_now[i] = glow_now[i] - 8'd2;
        px[ch] = glow_now[i];
      end
    end else begin
      for (int ch = 0; ch < cgpi_pkg::CHANNELS; ch++) begin
        acc = 0;
        for (int k = 0; k < cgpi_pkg::CORNERS; k++)
          acc += glow_weight[r][c][k] * glow_now[k*3+ch];
        px[ch] = 8'(acc >> cgpi_pkg::WEIGHT_FRAC_BITS);
      end
    end
    res.red = px[0];
    res.green = px[1];
    res.blue = px[2];
    return res;
  endfunction

  function automatic logic [3:0][7:0] random_hues();
    logic [3:0][7:0] hues;
    for (int k = 0; k < cgpi_pkg::CORNERS; k++) begin
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 7))
          0: hues[k] = 8'd0;
          1: hues[k] = cgpi_pkg::HUE_THIRD;
          2: hues[k] = cgpi_pkg::HUE_THIRD + 8'd1;
          3: hues[k] = cgpi_pkg::HUE_TWO_THIRDS - 8'd1;
          4: hues[k] = cgpi_pkg::HUE_TWO_THIRDS;
          5: hues[k] = cgpi_pkg::HUE_TWO_THIRDS + 8'd1;
          6: hues[k] = 8'd254;
          default: hues[k] = 8'd255;
        endcase
      end else begin
        hues[k] = 8'($urandom_range(0, 255));
      end
    end
    return hues;
  endfunction

  // entered and left at a falling edge
  task automatic drive_beat(input logic op, input logic [5:0] c, input logic [5:0] r,
                            input logic [3:0][7:0] hues, input bit known,
                            input glow_t typed);
    glow_t predicted;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    col       <= c;
    row       <= r;
    random_a  <= hues[0];
    random_b  <= hues[1];
    random_c  <= hues[2];
    random_d  <= hues[3];
    do @(posedge clk); while (in_stall);
    predicted = next_pixel_color(op, c, r, hues);
    pending_colors.push_back(known ? typed : predicted);
    @(negedge clk);
  endtask

  task automatic random_beat();
    int         kind;
    int         k;
    logic       op;
    logic [5:0] c;
    logic [5:0] r;
    kind = $urandom_range(0, 99);
    op = OP_PIXEL;
    if (kind < 50) begin
      k = $urandom_range(0, 3);
      c = (k & 1) ? 6'(cgpi_pkg::PANEL_WIDTH - 1) : 6'd0;
      r = (k & 2) ? 6'(cgpi_pkg::PANEL_HEIGHT - 1) : 6'd0;
    end else if (kind < 78) begin
      c = 6'($urandom_range(0, cgpi_pkg::PANEL_WIDTH - 1));
      r = 6'($urandom_range(0, cgpi_pkg::PANEL_HEIGHT - 1));
    end else begin
      c = 6'($urandom_range(0, 63));
      r = 6'($urandom_range(0, 63));
      if (kind >= 88) op = OP_FRAME_END;
    end
    drive_beat(op, c, r, random_hues(), 1'b0, '0);
  endtask

  task automatic raster_frame();
    for (int y = 0; y < cgpi_pkg::PANEL_HEIGHT; y++) begin
      for (int x = 0; x < cgpi_pkg::PANEL_WIDTH; x++) begin
        drive_beat(OP_PIXEL, 6'(x), 6'(y), random_hues(), 1'b0, '0);
      end
    end
    drive_beat(OP_FRAME_END, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
               random_hues(), 1'b0, '0);
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 15) - 1;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    glow_t want;
    glow_t seen;
    if (!rst && out_valid && !out_stall) begin
      seen = '{red, green, blue, retargeted};
      if (pending_colors.size() == 0) begin
        color_mismatches++;
        if (color_mismatches <= 10)
          $display("unexpected beat: r=%0d g=%0d b=%0d retargeted=%h",
                   red, green, blue, retargeted);
      end else begin
        want = pending_colors.pop_front();
        if (want.red !== seen.red || want.green !== seen.green ||
            want.blue !== seen.blue || want.retargeted !== seen.retargeted) begin
          color_mismatches++;
          if (color_mismatches <= 10)
            $display({"expected r=%0d g=%0d b=%0d retargeted=%h, ",
                      "got r=%0d g=%0d b=%0d retargeted=%h"},
                     want.red, want.green, want.blue, want.retargeted,
                     seen.red, seen.green, seen.blue, seen.retargeted);
        end
      end
    end
  end

  initial begin
    script_row_t s;
    build_weights();
    for (int i = 0; i < cgpi_pkg::CORNERS * cgpi_pkg::CHANNELS; i++) begin
      glow_now[i]  = 8'd0;
      glow_goal[i] = 8'd0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      s = glow_script[i];
      drive_beat(s.op, s.col, s.row, {s.rd, s.rc, s.rb, s.ra}, s.known,
                 '{s.er, s.eg, s.eb, s.em});
    end
    repeat (600) random_beat();
    raster_frame();
    repeat (300) random_beat();
    idle_on = 1'b0;
    repeat (150) random_beat();
    in_valid <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (color_mismatches == 0 && pending_colors.size() == 0) begin
      $display("corner_glow_pixel_interpolator_unit: match");
    end else begin
      $display("corner_glow_pixel_interpolator_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("corner_glow_pixel_interpolator_unit: mismatch");
    $finish;
  end

endmodule
